/* rtl/triangle_plane_clipper_core_macros.svh */
`ifndef TRIANGLE_PLANE_CLIPPER_CORE_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_CORE_MACROS_SVH

// Clocked check, quiet while reset is applied.
`define TPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that must also hold while reset is applied.
`define TPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/tpc_pkg.sv */
package tpc_pkg;

  // Field widths of the item formats
  localparam int CoordBits  = 32;
  localparam int FracBits   = 16;
  localparam int ColorBits  = 32;
  localparam int CfgIdxBits = 3;

  // Intersection parameter: unsigned fraction plus one integer bit (t may reach 1.0)
  localparam int TFracBits = 32;
  localparam int TBits     = TFracBits + 1;

  // Exact plane distance and divider operand widths
  localparam int ProdBits = 2 * CoordBits;
  localparam int DistBits = ProdBits + 2;
  localparam int DivBits  = DistBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [CfgIdxBits-1:0] {
    RegNormalX,
    RegNormalY,
    RegNormalZ,
    RegOffset
  } cfg_reg_e;

  // Source of one clipped polygon point: an original vertex or an edge crossing
  typedef enum logic [2:0] {
    PtV0,
    PtV1,
    PtV2,
    PtX0,
    PtX1
  } pt_sel_e;

  typedef struct packed {
    coord_t                 v0_x;
    coord_t                 v0_y;
    coord_t                 v0_z;
    coord_t                 v1_x;
    coord_t                 v1_y;
    coord_t                 v1_z;
    coord_t                 v2_x;
    coord_t                 v2_y;
    coord_t                 v2_z;
    logic [ColorBits-1:0]   tri_color;
  } tpc_in_t;

  typedef struct packed {
    coord_t                 out_v0_x;
    coord_t                 out_v0_y;
    coord_t                 out_v0_z;
    coord_t                 out_v1_x;
    coord_t                 out_v1_y;
    coord_t                 out_v1_z;
    coord_t                 out_v2_x;
    coord_t                 out_v2_y;
    coord_t                 out_v2_z;
    logic [ColorBits-1:0]   out_color;
    logic                   last_of_run;
  } tpc_out_t;

endpackage

/* rtl/tpc_divider.sv */
module tpc_divider (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tpc_pkg::DivBits-1:0]  num_i,
  input  logic [tpc_pkg::DivBits-1:0]  den_i,
  output logic [tpc_pkg::TBits-1:0]    quot_o
);
  import tpc_pkg::*;

  logic [DivBits-1:0] rem_q   [TBits];
  logic [DivBits-1:0] den_q   [TBits];
  logic [TBits-1:0]   quot_q  [TBits];
  logic [DivBits-1:0] rem_d   [TBits];
  logic [TBits-1:0]   quot_d  [TBits];
  logic [DivBits:0]   trial   [TBits];
  logic [DivBits-1:0] den_in  [TBits];
  logic [TBits-1:0]   quot_in [TBits];

  // One restoring step per stage, most significant quotient bit first
  genvar k;
  for (k = 0; k < TBits; k++) begin : g_step
    if (k == 0) begin : g_first
      assign trial[k]   = {1'b0, num_i};
      assign den_in[k]  = den_i;
      assign quot_in[k] = '0;
    end else begin : g_next
      assign trial[k]   = {rem_q[k-1], 1'b0};
      assign den_in[k]  = den_q[k-1];
      assign quot_in[k] = quot_q[k-1];
    end

    // Compare, subtract and shift in the next quotient bit
    always_comb begin
      if (trial[k] >= {1'b0, den_in[k]}) begin
        rem_d[k]  = DivBits'(trial[k] - {1'b0, den_in[k]});
        quot_d[k] = {quot_in[k][TBits-2:0], 1'b1};
      end else begin
        rem_d[k]  = trial[k][DivBits-1:0];
        quot_d[k] = {quot_in[k][TBits-2:0], 1'b0};
      end
    end

    // Advance the stage; hold while stalled
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_in[k];
        quot_q[k] <= quot_d[k];
      end
    end
  end

  assign quot_o = quot_q[TBits-1];

endmodule

/* rtl/triangle_plane_clipper_core.sv */
// Clips one triangle against the plane n.P + offset = 0 held in the four
// configuration registers; a vertex at zero distance or above is inside.
// An item enters on start when busy is low; its triangles appear on the
// result ports one per cycle with result_valid_o, the last one of each item
// flagged by last_of_run. Fully clipped items give nothing. The pipeline
// takes an item every cycle while busy is low; an item clipped to a
// quadrilateral yields two triangles, and the output stage then raises busy
// for one cycle while it registers the first of them. The depth comes
// mostly from the 33-stage bit-per-stage divider that forms the edge
// crossing parameter. Results cannot be held off by the receiver. Write the
// plane registers only while no item is in flight.
`include "triangle_plane_clipper_core_macros.svh"

module triangle_plane_clipper_core #(
  parameter int FRAC_BITS = tpc_pkg::FracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  tpc_pkg::tpc_in_t                item_i,
  output logic                            result_valid_o,
  output tpc_pkg::tpc_out_t               result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tpc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  tpc_pkg::coord_t                 cfg_data_i
);
  import tpc_pkg::*;

  localparam int DeltaBits = CoordBits + 1;
  localparam int MulBits   = TBits + DeltaBits;
  localparam int StepBits  = MulBits - TFracBits;
  localparam int SumBits   = CoordBits + 3;

  localparam coord_t OneFix   = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam pt_sel_e VtxCode [3] = '{PtV0, PtV1, PtV2};

  // Item data that rides alongside the divider
  typedef struct packed {
    logic                                two;
    pt_sel_e [3:0]                       lst;
    logic [ColorBits-1:0]                col;
    logic [2:0][2:0][CoordBits-1:0]      v;
    logic [1:0][2:0][CoordBits-1:0]      a;
    logic [1:0][2:0][DeltaBits-1:0]      dmag;
    logic [1:0][2:0]                     dneg;
  } side_t;

  // ---------------------------------------------------------------- config
  coord_t nrm_q [3];
  coord_t off_q;

  assign cfg_ready_o = 1'b1;

  // Take plane register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= OneFix;
      off_q    <= -OneFix;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegNormalX: nrm_q[0] <= cfg_data_i;
        RegNormalY: nrm_q[1] <= cfg_data_i;
        RegNormalZ: nrm_q[2] <= cfg_data_i;
        RegOffset:  off_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic stall;
  logic en;
  logic accept;
  logic sel_vld_q;
  logic sel_two_q;
  logic phase_q;

  // Hold the whole pipe while the first of two triangles goes out
  assign stall  = sel_vld_q && sel_two_q && !phase_q;
  assign en     = !stall;
  assign busy   = stall;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage 1: capture
  logic                 s1_vld_q;
  coord_t               s1_v_q [3][3];
  logic [ColorBits-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_q[0][0] <= item_i.v0_x;
      s1_v_q[0][1] <= item_i.v0_y;
      s1_v_q[0][2] <= item_i.v0_z;
      s1_v_q[1][0] <= item_i.v1_x;
      s1_v_q[1][1] <= item_i.v1_y;
      s1_v_q[1][2] <= item_i.v1_z;
      s1_v_q[2][0] <= item_i.v2_x;
      s1_v_q[2][1] <= item_i.v2_y;
      s1_v_q[2][2] <= item_i.v2_z;
      s1_col_q     <= item_i.tri_color;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic                        s2_vld_q;
  coord_t                      s2_v_q [3][3];
  logic [ColorBits-1:0]        s2_col_q;
  logic signed [ProdBits-1:0]  s2_prod_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_v_q   <= s1_v_q;
      s2_col_q <= s1_col_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s2_prod_q[i][k] <= s1_v_q[i][k] * nrm_q[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: distances
  logic signed [DistBits-1:0] dist_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dist_d[i] = DistBits'(s2_prod_q[i][0]) + DistBits'(s2_prod_q[i][1])
                + DistBits'(s2_prod_q[i][2]) + (DistBits'(off_q) <<< FRAC_BITS);
    end
  end

  logic                        s3_vld_q;
  coord_t                      s3_v_q [3][3];
  logic [ColorBits-1:0]        s3_col_q;
  logic signed [DistBits-1:0]  s3_dist_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_v_q    <= s2_v_q;
      s3_col_q  <= s2_col_q;
      s3_dist_q <= dist_d;
    end
  end

  // ---------------------------------------------------------------- stage 4: classify
  logic [2:0]          ins;
  pt_sel_e             lst_d [4];
  logic [1:0]          ca [2];
  logic [1:0]          cb [2];
  logic [2:0]          npts;
  logic [1:0]          ncross;
  logic [1:0]          nx;
  logic [DivBits-1:0]  num_d [2];
  logic [DivBits-1:0]  den_d [2];
  side_t               s4_side_d;
  logic                s4_vld_d;

  always_comb begin
    logic signed [DivBits-1:0]   da;
    logic signed [DivBits-1:0]   db;
    logic signed [DivBits-1:0]   diff;
    logic signed [DeltaBits-1:0] delta;

    for (int i = 0; i < 3; i++) begin
      ins[i] = !s3_dist_q[i][DistBits-1];
    end

    // Walk the edges in order: keep inside vertices, add crossings
    npts   = '0;
    ncross = '0;
    nx     = '0;
    lst_d  = '{default: PtV0};
    ca     = '{default: '0};
    cb     = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      nx = (i == 2) ? 2'd0 : 2'(i + 1);
      if (ins[i]) begin
        lst_d[npts[1:0]] = VtxCode[i];
        npts = npts + 3'd1;
      end
      if (ins[i] != ins[nx]) begin
        lst_d[npts[1:0]] = ncross[0] ? PtX1 : PtX0;
        ca[ncross[0]] = 2'(i);
        cb[ncross[0]] = nx;
        ncross = ncross + 2'd1;
        npts = npts + 3'd1;
      end
    end

    // Drop items that lie wholly outside
    s4_vld_d      = s3_vld_q && (|ins);
    s4_side_d.two = (npts == 3'd4);
    s4_side_d.col = s3_col_q;
    for (int j = 0; j < 4; j++) begin
      s4_side_d.lst[j] = lst_d[j];
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s4_side_d.v[i][k] = s3_v_q[i][k];
      end
    end

    // Divider operands and edge deltas for each crossing
    for (int c = 0; c < 2; c++) begin
      da   = DivBits'(s3_dist_q[ca[c]]);
      db   = DivBits'(s3_dist_q[cb[c]]);
      diff = db - da;
      num_d[c] = da[DivBits-1] ? DivBits'(-da) : DivBits'(da);
      den_d[c] = diff[DivBits-1] ? DivBits'(-diff) : DivBits'(diff);
      for (int k = 0; k < 3; k++) begin
        delta = DeltaBits'(s3_v_q[cb[c]][k]) - DeltaBits'(s3_v_q[ca[c]][k]);
        s4_side_d.a[c][k]    = s3_v_q[ca[c]][k];
        s4_side_d.dneg[c][k] = delta[DeltaBits-1];
        s4_side_d.dmag[c][k] = delta[DeltaBits-1] ? DeltaBits'(-delta) : DeltaBits'(delta);
      end
    end
  end

  logic                s4_vld_q;
  side_t               s4_side_q;
  logic [DivBits-1:0]  s4_num_q [2];
  logic [DivBits-1:0]  s4_den_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s4_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q <= s4_side_d;
      s4_num_q  <= num_d;
      s4_den_q  <= den_d;
    end
  end

  // ---------------------------------------------------------------- crossing parameter
  logic [TBits-1:0] quot [2];

  genvar gc;
  for (gc = 0; gc < 2; gc++) begin : g_div
    tpc_divider u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (s4_num_q[gc]),
      .den_i  (s4_den_q[gc]),
      .quot_o (quot[gc])
    );
  end

  // Delay the item data alongside the divider
  side_t             line_q [TBits];
  logic [TBits-1:0]  line_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
    end else if (en) begin
      line_vld_q <= {line_vld_q[TBits-2:0], s4_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_q[0] <= s4_side_q;
      for (int j = 1; j < TBits; j++) begin
        line_q[j] <= line_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- scale deltas by t
  logic                m_vld_q;
  side_t               m_side_q;
  logic [MulBits-1:0]  m_prod_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= line_vld_q[TBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q <= line_q[TBits-1];
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 3; k++) begin
          m_prod_q[c][k] <= MulBits'(quot[c]) * MulBits'(line_q[TBits-1].dmag[c][k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- crossing points
  coord_t x_d [2][3];

  always_comb begin
    logic [StepBits-1:0]        step;
    logic signed [SumBits-1:0]  sum;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 3; k++) begin
        step = m_prod_q[c][k][MulBits-1:TFracBits];
        if (m_side_q.dneg[c][k]) begin
          sum = SumBits'($signed(m_side_q.a[c][k])) - $signed(SumBits'(step));
        end else begin
          sum = SumBits'($signed(m_side_q.a[c][k])) + $signed(SumBits'(step));
        end
        // Saturate to the coordinate range
        if (sum > SumBits'(CoordMax)) begin
          x_d[c][k] = CoordMax;
        end else if (sum < SumBits'(CoordMin)) begin
          x_d[c][k] = CoordMin;
        end else begin
          x_d[c][k] = sum[CoordBits-1:0];
        end
      end
    end
  end

  logic    a_vld_q;
  side_t   a_side_q;
  coord_t  a_x_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= m_side_q;
      a_x_q    <= x_d;
    end
  end

  // ---------------------------------------------------------------- assemble triangles
  coord_t pt [4][3];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        case (a_side_q.lst[j])
          PtV0:    pt[j][k] = a_side_q.v[0][k];
          PtV1:    pt[j][k] = a_side_q.v[1][k];
          PtV2:    pt[j][k] = a_side_q.v[2][k];
          PtX0:    pt[j][k] = a_x_q[0][k];
          PtX1:    pt[j][k] = a_x_q[1][k];
          default: pt[j][k] = a_side_q.v[0][k];
        endcase
      end
    end
  end

  logic [ColorBits-1:0] sel_col_q;
  coord_t               sel_t0_q [3][3];
  coord_t               sel_t1_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
    end else if (en) begin
      sel_vld_q <= a_vld_q;
    end
  end

  // Fan the polygon into (p0,p1,p2) and (p0,p3,p2)
  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_two_q <= a_side_q.two;
      sel_col_q <= a_side_q.col;
      for (int k = 0; k < 3; k++) begin
        sel_t0_q[0][k] <= pt[0][k];
        sel_t0_q[1][k] <= pt[1][k];
        sel_t0_q[2][k] <= pt[2][k];
        sel_t1_q[0][k] <= pt[0][k];
        sel_t1_q[1][k] <= pt[3][k];
        sel_t1_q[2][k] <= pt[2][k];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  coord_t   tri_sel [3][3];
  logic     result_vld_q;
  tpc_out_t result_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        tri_sel[i][k] = phase_q ? sel_t1_q[i][k] : sel_t0_q[i][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_vld_q <= 1'b0;
      phase_q      <= 1'b0;
    end else begin
      result_vld_q <= sel_vld_q;
      phase_q      <= stall;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.out_v0_x    <= tri_sel[0][0];
    result_q.out_v0_y    <= tri_sel[0][1];
    result_q.out_v0_z    <= tri_sel[0][2];
    result_q.out_v1_x    <= tri_sel[1][0];
    result_q.out_v1_y    <= tri_sel[1][1];
    result_q.out_v1_z    <= tri_sel[1][2];
    result_q.out_v2_x    <= tri_sel[2][0];
    result_q.out_v2_y    <= tri_sel[2][1];
    result_q.out_v2_z    <= tri_sel[2][2];
    result_q.out_color   <= sel_col_q;
    result_q.last_of_run <= !sel_two_q || phase_q;
  end

  assign result_valid_o = result_vld_q;
  assign result_o       = result_q;

  // ---------------------------------------------------------------- checks
  `TPC_ASSERT(a_pair_follows, result_valid_o && !result_o.last_of_run |=> result_valid_o && result_o.last_of_run, "second triangle of a pair missing")
  `TPC_ASSERT(a_pair_colour, result_valid_o && !result_o.last_of_run |=> $stable(result_o.out_color), "colour changed within a pair")
  `TPC_ASSERT(a_busy_single, busy |=> !busy && result_valid_o && !result_o.last_of_run, "busy not matched to first triangle of a pair")
  `TPC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !busy && !result_valid_o, "activity during reset")

endmodule
